// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define VDM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define VDM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/vdm_pkg.sv =====
// Package: types, codes and constants of the vector distance block.
`timescale 1ns / 1ps
package vdm_pkg;

  localparam int MAX_LENGTH_DEF = 65536;
  localparam int DIST_W = 48;
  localparam int ACC_W = 64;
  localparam logic [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};

  localparam logic [2:0] M_EUCLID = 3'd0;
  localparam logic [2:0] M_SUP    = 3'd1;
  localparam logic [2:0] M_INF    = 3'd2;
  localparam logic [2:0] M_MANH   = 3'd3;
  localparam logic [2:0] M_CANB   = 3'd4;
  localparam logic [2:0] M_RCANB  = 3'd5;
  localparam logic [2:0] M_MINK   = 3'd6;
  localparam logic [2:0] M_BIN    = 3'd7;

  localparam logic REG_METRIC = 1'b0;
  localparam logic REG_POWER  = 1'b1;

  typedef struct packed {
    logic signed [15:0] x_val;
    logic signed [15:0] y_val;
    logic               last;
  } in_t;

  typedef struct packed {
    logic signed [DIST_W-1:0] distance;
    logic                     saturated;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE, S_ELEM, S_MUL, S_DIV, S_ACC, S_CHK, S_FIN, S_ROOT, S_FDIV, S_DONE
  } vdm_state_t;

  typedef enum logic [1:0] {
    R_IDLE, R_SQRT, R_CMUL, R_CCMP
  } root_state_t;

endpackage

// ===== src/vector_distance_metric.sv =====
// Per beat: the sequencer steps through its states; a Canberra term waits on the divider (one divider bit a cycle).
// A last beat adds the final step: a root where the metric needs one, or a division for the binary ratio.
// Throughput: one beat at a time; in_stall is low only while the sequencer idles.
// Reset (synchronous, rst_n low): metric 0, power 2, accumulators and result valid cleared.
// Top level: sequencer, accumulators and shared multiplier of the distance block.
`timescale 1ns / 1ps
module vector_distance_metric
  import vdm_pkg::*;
#(
  parameter int MAX_LENGTH = MAX_LENGTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_t       out_data,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [2:0] cfg_wdata
);
  localparam int CW = $clog2(MAX_LENGTH + 1);
  localparam int NW = (CW + 16 > 32) ? CW + 16 : 32;
  localparam int DW = (CW > 17) ? CW : 17;

  vdm_state_t st_r, st_nxt;
  logic [2:0]         metric_r, metric_nxt, power_r, power_nxt;
  logic signed [15:0] x_r, y_r;
  logic               last_r;
  logic [ACC_W-1:0]   sum_r, sum_nxt, term_r, term_nxt;
  logic [CW-1:0]      on_r, on_nxt;
  logic signed [17:0] best_r, best_nxt;
  logic               have_r, have_nxt, ovf_r, ovf_nxt;
  logic [2:0]         cnt_r, cnt_nxt;
  logic [DIST_W-1:0]  dist_r, dist_nxt;
  logic               fsat_r, fsat_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_r, out_nxt;

  logic [2:0]   eff_p;
  logic [16:0]  sx, sy, d_w, ax, ay, sxy, den_c, den_rev;
  logic [15:0]  ad;
  logic [17:0]  bm;
  logic         take_it;
  logic [ACC_W:0] acc_sum;
  logic [CW-1:0]  mism;
  logic         div_start, div_done;
  logic [NW-1:0] div_num, div_quo;
  logic [DW-1:0] div_den;
  logic         root_start, root_done;
  logic [2:0]   root_pw;
  logic [DIST_W-1:0] root_val;

  vdm_div #(.NW(NW), .DW(DW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  vdm_root u_root (
    .clk(clk), .rst_n(rst_n), .start(root_start), .pw(root_pw), .s(sum_r),
    .done(root_done), .root(root_val)
  );

  always_comb begin
    eff_p = (power_r == 3'd0) ? 3'd1 : ((power_r > 3'd4) ? 3'd4 : power_r);
    sx = {x_r[15], x_r};
    sy = {y_r[15], y_r};
    d_w = sx - sy;
    ad = d_w[16] ? 16'(-d_w) : d_w[15:0];
    ax = sx[16] ? 17'(-sx) : sx;
    ay = sy[16] ? 17'(-sy) : sy;
    sxy = sx + sy;
    den_rev = sxy[16] ? 17'(-sxy) : sxy;
    den_c = ax + ay;
    bm = best_r[17] ? 18'(-best_r) : 18'(best_r);
    take_it = !have_r || ((metric_r == M_SUP) ? ({2'b00, ad} > bm) : ({2'b00, ad} < bm));
    acc_sum = {1'b0, sum_r} + {1'b0, term_r};
    mism = (sum_r < ACC_W'(on_r)) ? CW'(sum_r) : on_r;

    st_nxt = st_r;
    metric_nxt = metric_r;
    power_nxt = power_r;
    sum_nxt = sum_r;
    term_nxt = term_r;
    on_nxt = on_r;
    best_nxt = best_r;
    have_nxt = have_r;
    ovf_nxt = ovf_r;
    cnt_nxt = cnt_r;
    dist_nxt = dist_r;
    fsat_nxt = fsat_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt = out_r;
    div_start = 1'b0;
    div_num = NW'({ad, 16'd0});
    div_den = DW'((metric_r == M_CANB) ? den_c : den_rev);
    root_start = 1'b0;
    root_pw = (metric_r == M_EUCLID) ? 3'd2 : eff_p;

    if (cfg_we) begin
      if (cfg_index == REG_METRIC) metric_nxt = cfg_wdata;
      else power_nxt = cfg_wdata;
    end

    case (st_r)
      S_IDLE: begin
        if (in_valid) st_nxt = S_ELEM;
      end
      S_ELEM: begin
        case (metric_r)
          M_EUCLID: begin
            term_nxt = 64'd1;
            cnt_nxt = 3'd2;
            st_nxt = S_MUL;
          end
          M_MINK: begin
            term_nxt = 64'd1;
            cnt_nxt = eff_p;
            st_nxt = S_MUL;
          end
          M_MANH: begin
            term_nxt = ACC_W'(ad);
            st_nxt = S_ACC;
          end
          M_CANB, M_RCANB: begin
            if (div_den == '0) begin
              st_nxt = S_CHK;
            end else begin
              div_start = 1'b1;
              st_nxt = S_DIV;
            end
          end
          M_SUP, M_INF: begin
            if (take_it) best_nxt = {d_w[16], d_w};
            have_nxt = 1'b1;
            st_nxt = S_CHK;
          end
          default: begin
            if (x_r != 16'sd0 || y_r != 16'sd0) begin
              if (on_r < CW'(MAX_LENGTH)) on_nxt = on_r + 1'b1;
              else ovf_nxt = 1'b1;
              if (x_r == 16'sd0 || y_r == 16'sd0) begin
                if (sum_r < ACC_W'(MAX_LENGTH)) sum_nxt = sum_r + 1'b1;
                else ovf_nxt = 1'b1;
              end
            end
            st_nxt = S_CHK;
          end
        endcase
      end
      S_MUL: begin
        term_nxt = 64'(term_r[47:0] * ad);
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == 3'd1) st_nxt = S_ACC;
      end
      S_DIV: begin
        if (div_done) begin
          term_nxt = ACC_W'(div_quo);
          st_nxt = S_ACC;
        end
      end
      S_ACC: begin
        if (acc_sum[ACC_W]) begin
          sum_nxt = '1;
          ovf_nxt = 1'b1;
        end else begin
          sum_nxt = acc_sum[ACC_W-1:0];
        end
        st_nxt = S_CHK;
      end
      S_CHK: begin
        st_nxt = last_r ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        fsat_nxt = ovf_r;
        st_nxt = S_DONE;
        case (metric_r)
          M_EUCLID, M_MINK, M_MANH: begin
            if (metric_r != M_MANH && !(metric_r == M_MINK && eff_p == 3'd1)) begin
              root_start = 1'b1;
              st_nxt = S_ROOT;
            end else if (sum_r[63:39] != '0) begin
              dist_nxt = DIST_MAX;
              fsat_nxt = 1'b1;
            end else begin
              dist_nxt = {1'b0, sum_r[38:0], 8'd0};
            end
          end
          M_SUP, M_INF: dist_nxt = {{22{best_r[17]}}, best_r, 8'd0};
          M_CANB, M_RCANB: begin
            if (sum_r > ACC_W'(DIST_MAX)) begin
              dist_nxt = DIST_MAX;
              fsat_nxt = 1'b1;
            end else begin
              dist_nxt = sum_r[DIST_W-1:0];
            end
          end
          default: begin
            if (on_r == '0) begin
              dist_nxt = '0;
            end else begin
              div_num = NW'({mism, 16'd0});
              div_den = DW'(on_r);
              div_start = 1'b1;
              st_nxt = S_FDIV;
            end
          end
        endcase
      end
      S_ROOT: begin
        if (root_done) begin
          dist_nxt = root_val;
          st_nxt = S_DONE;
        end
      end
      S_FDIV: begin
        if (div_done) begin
          dist_nxt = DIST_W'(div_quo);
          st_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_nxt.distance = dist_r;
          out_nxt.saturated = fsat_r;
          sum_nxt = '0;
          on_nxt = '0;
          best_nxt = '0;
          have_nxt = 1'b0;
          ovf_nxt = 1'b0;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_r == S_IDLE && in_valid) begin
      x_r <= in_data.x_val;
      y_r <= in_data.y_val;
      last_r <= in_data.last;
    end
    term_r <= term_nxt;
    cnt_r <= cnt_nxt;
    dist_r <= dist_nxt;
    fsat_r <= fsat_nxt;
    out_r <= out_nxt;
    if (!rst_n) begin
      st_r <= S_IDLE;
      metric_r <= M_EUCLID;
      power_r <= 3'd2;
      sum_r <= '0;
      on_r <= '0;
      best_r <= '0;
      have_r <= 1'b0;
      ovf_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      metric_r <= metric_nxt;
      power_r <= power_nxt;
      sum_r <= sum_nxt;
      on_r <= on_nxt;
      best_r <= best_nxt;
      have_r <= have_nxt;
      ovf_r <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall = (st_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data = out_r;
endmodule

// ===== src/vdm_div.sv =====
// Restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps
module vdm_div #(
  parameter int NW = 32,
  parameter int DW = 17
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);
  localparam int CNT_W = $clog2(NW + 1);

  logic [NW-1:0]    num_r, num_nxt;
  logic [DW-1:0]    den_r, den_nxt;
  logic [DW-1:0]    rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DW:0]      sh;
  logic             ge;

  always_comb begin
    sh = {rem_r, num_r[NW-1]};
    ge = sh >= {1'b0, den_r};
    num_nxt = num_r;
    den_nxt = den_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      num_nxt = num;
      den_nxt = den;
      rem_nxt = '0;
      cnt_nxt = CNT_W'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? DW'(sh - {1'b0, den_r}) : DW'(sh);
      num_nxt = {num_r[NW-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quo = num_r;
endmodule

// ===== src/vdm_root.sv =====
// Integer root unit: bitwise square root (twice for fourth root) and cube root.
`timescale 1ns / 1ps
module vdm_root
  import vdm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [2:0]        pw,
  input  logic [ACC_W-1:0]  s,
  output logic              done,
  output logic [DIST_W-1:0] root
);
  root_state_t  st_r, st_nxt;
  logic [95:0]  n_r, n_nxt;
  logic [49:0]  rem_r, rem_nxt;
  logic [47:0]  rt_r, rt_nxt;
  logic [5:0]   cnt_r, cnt_nxt;
  logic         pass2_r, pass2_nxt;
  logic         cube_r, cube_nxt;
  logic [87:0]  cx_r, cx_nxt;
  logic [30:0]  cy_r, cy_nxt;
  logic [61:0]  prod_r, prod_nxt;
  logic [4:0]   k_r, k_nxt;
  logic         done_r, done_nxt;
  logic [51:0]  sh, trial;
  logic         sq_ge;
  logic [47:0]  rt_step;
  logic [30:0]  y2;
  logic [63:0]  b;
  logic [6:0]   amt;
  logic [87:0]  xs;
  logic         c_ge;

  always_comb begin
    sh = {rem_r, n_r[95:94]};
    trial = {2'b00, rt_r, 2'b01};
    sq_ge = sh >= trial;
    rt_step = {rt_r[46:0], sq_ge};
    y2 = {cy_r[29:0], 1'b0};
    b = 64'(prod_r) * 64'd3 + 64'd1;
    amt = 7'(k_r) * 7'd3;
    xs = cx_r >> amt;
    c_ge = xs >= 88'(b);

    st_nxt = st_r;
    n_nxt = n_r;
    rem_nxt = rem_r;
    rt_nxt = rt_r;
    cnt_nxt = cnt_r;
    pass2_nxt = pass2_r;
    cube_nxt = cube_r;
    cx_nxt = cx_r;
    cy_nxt = cy_r;
    prod_nxt = prod_r;
    k_nxt = k_r;
    done_nxt = 1'b0;
    case (st_r)
      R_IDLE: begin
        if (start) begin
          rem_nxt = '0;
          rt_nxt = '0;
          cnt_nxt = 6'd47;
          cx_nxt = {s, 24'd0};
          cy_nxt = '0;
          k_nxt = 5'd29;
          cube_nxt = (pw == 3'd3);
          pass2_nxt = (pw == 3'd4);
          n_nxt = (pw == 3'd4) ? {s, 32'd0} : {16'd0, s, 16'd0};
          st_nxt = (pw == 3'd3) ? R_CMUL : R_SQRT;
        end
      end
      R_SQRT: begin
        rem_nxt = sq_ge ? 50'(sh - trial) : 50'(sh);
        rt_nxt = rt_step;
        n_nxt = {n_r[93:0], 2'b00};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          if (pass2_r) begin
            pass2_nxt = 1'b0;
            n_nxt = {48'd0, rt_step};
            rem_nxt = '0;
            rt_nxt = '0;
            cnt_nxt = 6'd47;
          end else begin
            done_nxt = 1'b1;
            st_nxt = R_IDLE;
          end
        end
      end
      R_CMUL: begin
        prod_nxt = y2 * (y2 + 31'd1);
        st_nxt = R_CCMP;
      end
      R_CCMP: begin
        if (c_ge) begin
          cx_nxt = cx_r - (88'(b) << amt);
        end
        cy_nxt = y2 + 31'(c_ge);
        k_nxt = k_r - 1'b1;
        if (k_r == '0) begin
          done_nxt = 1'b1;
          st_nxt = R_IDLE;
        end else begin
          st_nxt = R_CMUL;
        end
      end
      default: st_nxt = R_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    n_r <= n_nxt;
    rem_r <= rem_nxt;
    rt_r <= rt_nxt;
    cnt_r <= cnt_nxt;
    pass2_r <= pass2_nxt;
    cube_r <= cube_nxt;
    cx_r <= cx_nxt;
    cy_r <= cy_nxt;
    prod_r <= prod_nxt;
    k_r <= k_nxt;
    if (!rst_n) begin
      st_r <= R_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign root = cube_r ? DIST_W'(cy_r) : DIST_W'(rt_r);
endmodule

// ===== src/vdm_checker.sv =====
// Port checker of the distance block and its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module vdm_checker
  import vdm_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input in_t  in_data,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);
  `VDM_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled result beat changed")
  `VDM_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> !out_valid, "result beat shown right after reset")
  `VDM_ASSERT(a_busy_after, in_valid && !in_stall |=> in_stall, "input taken on back-to-back cycles")
  `VDM_ASSERT(a_no_early, in_valid && !in_stall && !in_data.last |=> !$rose(out_valid), "result beat without a last beat")
endmodule

bind vector_distance_metric vdm_checker u_vdm_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

// ===== tb/tb_vector_distance_metric.sv =====
// Testbench: random and directed vectors against a bit-exact distance predictor.
`timescale 1ns / 1ps
module tb_vector_distance_metric;
  import vdm_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_WAIT  = 200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_METRIC;
  logic [2:0] cfg_wdata = '0;

  vector_distance_metric u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  in_t  pending_beats[$];
  out_t due_dist[$];
  int   tx_idle_pct = 0;
  int   rx_stall_pct = 0;
  bit   hold_req = 0;
  int   hold_cnt = 0;
  bit   beat_taken = 0;
  int   mismatches = 0;
  int   cycles = 0;

  logic [2:0]  cur_metric = M_EUCLID;
  logic [2:0]  cur_power = 3'd2;
  logic [63:0] sum_acc = '0;
  logic [63:0] on_cnt = '0;
  int          best_d = 0;
  bit          have_best = 0;
  bit          acc_ovf = 0;

  function automatic int eff_power();
    if (cur_power < 1) return 1;
    if (cur_power > 4) return 4;
    return cur_power;
  endfunction

  function automatic void add_sum(logic [63:0] v);
    if (sum_acc > ~64'd0 - v) begin
      sum_acc = ~64'd0;
      acc_ovf = 1;
    end else begin
      sum_acc = sum_acc + v;
    end
  endfunction

  function automatic logic [255:0] pow_wide(logic [47:0] c, int p);
    logic [255:0] acc;
    acc = 256'd1;
    for (int k = 0; k < p; k++) acc = acc * c;
    return acc;
  endfunction

  function automatic logic [47:0] int_root(logic [63:0] s, int p, inout bit sat);
    logic [255:0] tgt;
    logic [47:0]  r;
    logic [47:0]  cand;
    tgt = {192'd0, s} << (8 * p);
    r = '0;
    for (int b = 46; b >= 0; b--) begin
      cand = r | (48'd1 << b);
      if (pow_wide(cand, p) <= tgt) r = cand;
    end
    if (pow_wide(48'd1 << 47, p) <= tgt) sat = 1;
    return r;
  endfunction

  function automatic void accumulate_pair(in_t b);
    int x, y, d, ad, den;
    logic [63:0] t, mism;
    logic [47:0] r;
    bit sat;
    out_t res;
    x = b.x_val;
    y = b.y_val;
    d = x - y;
    ad = d < 0 ? -d : d;
    case (cur_metric)
      M_EUCLID: add_sum(64'(ad) * 64'(ad));
      M_SUP, M_INF: begin
        if (!have_best || (cur_metric == M_SUP ? ad > (best_d < 0 ? -best_d : best_d)
                                               : ad < (best_d < 0 ? -best_d : best_d)))
          best_d = d;
        have_best = 1;
      end
      M_MANH: add_sum(64'(ad));
      M_CANB, M_RCANB: begin
        den = cur_metric == M_CANB ? (x < 0 ? -x : x) + (y < 0 ? -y : y)
                                   : ((x + y) < 0 ? -(x + y) : (x + y));
        if (den != 0) add_sum((64'(ad) << 16) / 64'(den));
      end
      M_MINK: begin
        t = 64'd1;
        for (int k = 0; k < eff_power(); k++) t = t * 64'(ad);
        add_sum(t);
      end
      default: begin
        if (x != 0 || y != 0) begin
          if (on_cnt < MAX_LENGTH_DEF) on_cnt++;
          else acc_ovf = 1;
          if (!(x != 0 && y != 0)) begin
            if (sum_acc < MAX_LENGTH_DEF) sum_acc++;
            else acc_ovf = 1;
          end
        end
      end
    endcase
    if (!b.last) return;
    sat = acc_ovf;
    case (cur_metric)
      M_EUCLID: r = int_root(sum_acc, 2, sat);
      M_SUP, M_INF: r = 48'(best_d * 256);
      M_MANH: r = int_root(sum_acc, 1, sat);
      M_CANB, M_RCANB: begin
        if (sum_acc > 64'(DIST_MAX)) begin
          r = DIST_MAX;
          sat = 1;
        end else begin
          r = sum_acc[47:0];
        end
      end
      M_MINK: r = int_root(sum_acc, eff_power(), sat);
      default: begin
        mism = sum_acc < on_cnt ? sum_acc : on_cnt;
        r = on_cnt != 0 ? 48'((mism << 16) / on_cnt) : '0;
      end
    endcase
    res.distance = r;
    res.saturated = sat;
    due_dist.push_back(res);
    sum_acc = '0;
    on_cnt = '0;
    best_d = 0;
    have_best = 0;
    acc_ovf = 0;
  endfunction

  // monitor: accept beats, predict, check results
  always @(posedge clk) begin
    out_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
    if (rst_n && in_valid && !in_stall) begin
      beat_taken = 1;
      accumulate_pair(in_data);
    end
    if (rst_n && out_valid && !out_stall) begin
      if (due_dist.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_data);
      end else begin
        want = due_dist.pop_front();
        if (out_data.distance !== want.distance || out_data.saturated !== want.saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected dist %h sat %b, got dist %h sat %b",
                     want.distance, want.saturated, out_data.distance, out_data.saturated);
        end
      end
    end
  end

  // driver: hold a beat until taken
  always @(negedge clk) begin
    if (rst_n && (!in_valid || beat_taken)) begin
      beat_taken = 0;
      if (pending_beats.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= pending_beats.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 0;
      hold_cnt = 600;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  task automatic push_pair(int x, int y, bit lst);
    in_t b;
    b.x_val = 16'(x);
    b.y_val = 16'(y);
    b.last = lst;
    pending_beats.push_back(b);
  endtask

  task automatic drain();
    while (pending_beats.size() != 0 || in_valid || due_dist.size() != 0)
      @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [2:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == REG_METRIC) cur_metric = val;
    else cur_power = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic int rand_elem();
    case ($urandom_range(5))
      0, 1: return 0;
      2: return $urandom_range(1) ? 32767 : -32768;
      3: return int'($urandom_range(40)) - 20;
      default: return int'($urandom_range(65535)) - 32768;
    endcase
  endfunction

  task automatic random_phase(int n_items);
    int done, len;
    done = 0;
    while (done < n_items) begin
      drain();
      write_reg(REG_METRIC, 3'($urandom_range(7)));
      write_reg(REG_POWER, 3'($urandom_range(7)));
      for (int v = 0; v < 6; v++) begin
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
          // sometimes leave a vector open across the next register change
          push_pair(rand_elem(), rand_elem(), k == len - 1 && !(v == 5 && $urandom_range(9) == 0));
          done++;
        end
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    push_pair(32767, -32768, 0);
    push_pair(-32768, 32767, 1);
    push_pair(0, 0, 1);
    drain();
    write_reg(REG_METRIC, M_SUP);
    push_pair(3, 1, 0); push_pair(-1, 1, 0); push_pair(5, 3, 1);
    drain();
    write_reg(REG_METRIC, M_INF);
    push_pair(3, 1, 0); push_pair(-1, 1, 0); push_pair(-32768, 32767, 1);
    drain();
    write_reg(REG_METRIC, M_CANB);
    push_pair(0, 0, 0); push_pair(256, -256, 1);
    drain();
    write_reg(REG_METRIC, M_RCANB);
    push_pair(5, -5, 0); push_pair(7, 1, 1);
    drain();
    write_reg(REG_METRIC, M_MINK);
    write_reg(REG_POWER, 3'd0);
    push_pair(10, 3, 1);
    drain();
    write_reg(REG_POWER, 3'd7);
    push_pair(32767, -32768, 0); push_pair(-32768, 32767, 1);
    drain();
    write_reg(REG_METRIC, M_BIN);
    push_pair(0, 0, 0); push_pair(0, 0, 1);
    push_pair(1, 0, 0); push_pair(2, 2, 0); push_pair(0, -3, 1);
    drain();
    write_reg(REG_METRIC, M_MANH);
    push_pair(10, 2, 0);
    drain();
    write_reg(REG_METRIC, M_EUCLID);
    push_pair(3, 4, 1);

    tx_idle_pct = 33; rx_stall_pct = 67;
    drain();
    hold_req = 1;
    random_phase(230);
    tx_idle_pct = 67; rx_stall_pct = 33;
    random_phase(230);
    tx_idle_pct = 0; rx_stall_pct = 0;
    random_phase(230);
    drain();

    if (mismatches == 0 && due_dist.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
